[sv/face_reference_best_match_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the face reference best match core
// Checks are compiled for simulation only and vanish in synthesis.
// ---------------------------------------------------------------------------
`ifndef FACE_REFERENCE_BEST_MATCH_CORE_DEFINES_SVH
`define FACE_REFERENCE_BEST_MATCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked outside reset only.
`define FRBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked during reset as well.
`define FRBM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FRBM_ASSERT(lbl, prop, msg)
`define FRBM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/frbm_pkg.sv]
// ---------------------------------------------------------------------------
// frbm_pkg
// Types and constants shared by the face reference best match core.
// ---------------------------------------------------------------------------
package frbm_pkg;

    localparam int COORD_W = 21;
    localparam int NORM_W  = 16;
    localparam int AREA_W  = 32;
    localparam int IDX_W   = 32;
    localparam int DIAG_W  = 44;
    localparam int SCORE_W = 32;
    localparam int DIST_W  = 44;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 63;
    localparam int IN_W    = 176;
    localparam int OUT_W   = 64;
    localparam int STEPS   = 32;
    localparam int CNT_W   = 5;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] REG_CENTER = 3'd0;
    localparam logic [CFG_AW-1:0] REG_PICKED = 3'd1;
    localparam logic [CFG_AW-1:0] REG_NORMAL = 3'd2;
    localparam logic [CFG_AW-1:0] REG_AREA   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_DIAG   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_INDEX  = 3'd5;

    // Product groups of the multiply sweep.
    localparam logic [2:0] GRP_DC   = 3'd0;
    localparam logic [2:0] GRP_DP   = 3'd1;
    localparam logic [2:0] GRP_RR   = 3'd2;
    localparam logic [2:0] GRP_NN   = 3'd3;
    localparam logic [2:0] GRP_RN   = 3'd4;
    localparam logic [2:0] GRP_NRNC = 3'd5;
    localparam logic [2:0] GRP_END  = 3'd6;

    localparam logic [1:0] LANE_LAST = 2'd2;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_MUL     = 12'b0000_0000_0010,
        S_PREP_D  = 12'b0000_0000_0100,
        S_PREP_N  = 12'b0000_0000_1000,
        S_SQRT    = 12'b0000_0001_0000,
        S_PREP_ND = 12'b0000_0010_0000,
        S_PREP_A  = 12'b0000_0100_0000,
        S_DIV     = 12'b0000_1000_0000,
        S_DEND    = 12'b0001_0000_0000,
        S_WMUL    = 12'b0010_0000_0000,
        S_WACC    = 12'b0100_0000_0000,
        S_FIN     = 12'b1000_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        TERM_DIST = 2'd0,
        TERM_NORM = 2'd1,
        TERM_AREA = 2'd2
    } t_term;

endpackage

[sv/face_reference_best_match_core.sv]
// ---------------------------------------------------------------------------
// face_reference_best_match_core
// Scores candidate faces against a reference face and reports the best one.
// ---------------------------------------------------------------------------
// A scored candidate needs at most a multiply sweep on the
// shared multiplier, three 32-step passes of the restoring divider and one
// 32-step square root pass. A candidate without reference geometry skips them.
// Only one candidate is in flight; a result waits in the output register.
// Reset (synchronous, active low) sets the registers to their defaults, closes
// the run and empties the output register.
`include "face_reference_best_match_core_defines.svh"

module face_reference_best_match_core
    import frbm_pkg::*;
#(
    parameter int SCORE_FRAC_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // cand_center_x, _y, _z, cand_normal_x, _y, _z, cand_area, cand_face_index, pad
    input  logic [IN_W-1:0]   i_s_axis_tdata,
    input  logic              i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // best_face_index, best_score
    output logic [OUT_W-1:0]  o_m_axis_tdata,
    // used_geometry
    output logic              o_m_axis_tuser
);

    localparam int S      = SCORE_FRAC_BITS;
    localparam int NW     = DIST_W + S;
    localparam int ONE_Q  = 1 << S;
    localparam int W20    = (ONE_Q + 2) / 5;
    localparam int W05    = (ONE_Q + 10) / 20;
    localparam int SAT_SH = SCORE_W - S;

    // Configuration registers.
    logic [CFG_DW-1:0] r_ref_center, r_ref_picked;
    logic [47:0]       r_ref_normal;
    logic [AREA_W-1:0] r_ref_area;
    logic [DIAG_W-1:0] r_diag;
    logic [IDX_W-1:0]  r_ref_index;

    t_state r_state;
    t_term  r_term;

    // Candidate latched at accept.
    logic signed [COORD_W-1:0] r_cc [3];
    logic signed [NORM_W-1:0]  r_cn [3];
    logic [AREA_W-1:0]         r_ca;
    logic [IDX_W-1:0]          r_cidx;
    logic                      r_last, r_geom;

    // Multiply sweep.
    logic [2:0]          r_grp, r_acc_grp;
    logic [1:0]          r_lane;
    logic                r_acc_en;
    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  r_prod;
    logic [DIST_W-1:0]   r_dc, r_dp;
    logic [31:0]         r_nr, r_nc;
    logic signed [32:0]  r_dot;
    logic [63:0]         r_nn;
    logic [33:0]         r_total;

    // Divider and square root.
    logic [CNT_W-1:0]  r_cnt;
    logic [DIAG_W-1:0] r_drem, r_dden;
    logic [31:0]       r_dq;
    logic [63:0]       r_sval;
    logic [34:0]       r_srem;
    logic [31:0]       r_sroot;

    // Run and output state.
    logic                r_run_open;
    logic [SCORE_W-1:0]  r_best_score;
    logic [IDX_W-1:0]    r_best_idx;
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_idx;
    logic [SCORE_W-1:0]  r_out_score;
    logic                r_out_geom;

    // Reference fields and differences.
    logic signed [COORD_W-1:0] ref_c [3];
    logic signed [COORD_W-1:0] ref_p [3];
    logic signed [NORM_W-1:0]  ref_n [3];
    logic signed [COORD_W:0]   diff_c [3];
    logic signed [COORD_W:0]   diff_p [3];
    logic have_c, have_p, have_n, has_geom;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ref_c[k]  = r_ref_center[k*COORD_W +: COORD_W];
            ref_p[k]  = r_ref_picked[k*COORD_W +: COORD_W];
            ref_n[k]  = r_ref_normal[k*NORM_W +: NORM_W];
            diff_c[k] = {ref_c[k][COORD_W-1], ref_c[k]} - {r_cc[k][COORD_W-1], r_cc[k]};
            diff_p[k] = {ref_p[k][COORD_W-1], ref_p[k]} - {r_cc[k][COORD_W-1], r_cc[k]};
        end
    end

    assign have_c   = |r_ref_center;
    assign have_p   = |r_ref_picked;
    assign have_n   = |r_ref_normal;
    assign has_geom = have_c || have_p || have_n || (|r_ref_area);

    // Shared multiplier operand select.
    logic [31:0] pen;
    logic [31:0] cq;
    always_comb begin
        cq  = (r_dq > 32'(ONE_Q)) ? 32'(ONE_Q) : r_dq;
        pen = (r_term == TERM_NORM) ? 32'(ONE_Q) - cq : r_dq;
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_WMUL) begin
            mul_a = {1'b0, pen};
            mul_b = (r_term == TERM_NORM) ? 33'(W20) : 33'(W05);
        end else begin
            case (r_grp)
                GRP_DC: begin
                    mul_a = {{11{diff_c[r_lane][COORD_W]}}, diff_c[r_lane]};
                    mul_b = mul_a;
                end
                GRP_DP: begin
                    mul_a = {{11{diff_p[r_lane][COORD_W]}}, diff_p[r_lane]};
                    mul_b = mul_a;
                end
                GRP_RR: begin
                    mul_a = {{17{ref_n[r_lane][NORM_W-1]}}, ref_n[r_lane]};
                    mul_b = mul_a;
                end
                GRP_NN: begin
                    mul_a = {{17{r_cn[r_lane][NORM_W-1]}}, r_cn[r_lane]};
                    mul_b = mul_a;
                end
                GRP_RN: begin
                    mul_a = {{17{ref_n[r_lane][NORM_W-1]}}, ref_n[r_lane]};
                    mul_b = {{17{r_cn[r_lane][NORM_W-1]}}, r_cn[r_lane]};
                end
                GRP_NRNC: begin
                    mul_a = {1'b0, r_nr};
                    mul_b = {1'b0, r_nc};
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Distance pick and saturation check.
    logic [DIST_W-1:0] d_min;
    logic [DIAG_W-1:0] dg_eff;
    logic              d_ovf;
    always_comb begin
        if (have_c && !(have_p && (r_dp < r_dc))) begin
            d_min = r_dc;
        end else begin
            d_min = r_dp;
        end
        dg_eff = (r_diag == '0) ? DIAG_W'(1) : r_diag;
        d_ovf  = {20'b0, d_min} >= ({20'b0, dg_eff} << SAT_SH);
    end

    // Divider step.
    logic [DIAG_W:0] div_t;
    logic            div_ge;
    assign div_t  = {r_drem, r_dq[31]};
    assign div_ge = div_t >= {1'b0, r_dden};

    // Square root step.
    logic [34:0] sq_t, sq_trial;
    logic        sq_ge;
    assign sq_t     = {r_srem[32:0], r_sval[63:62]};
    assign sq_trial = {1'b0, r_sroot, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;

    // Operands of the normal and area quotients.
    logic [31:0]   dot_abs;
    logic [31:0]   a_max, a_diff;
    logic [NW-1:0] num_d, num_n, num_a;
    always_comb begin
        dot_abs = r_dot[32] ? 32'(-r_dot) : 32'(r_dot);
        a_max   = (r_ref_area > r_ca) ? r_ref_area : r_ca;
        a_diff  = (r_ref_area > r_ca) ? r_ref_area - r_ca : r_ca - r_ref_area;
        num_d   = {d_min, {S{1'b0}}};
        num_n   = {12'b0, dot_abs, {S{1'b0}}};
        num_a   = {12'b0, a_diff, {S{1'b0}}};
    end

    // Final score and run update.
    logic [SCORE_W-1:0] s_sat;
    logic               upd, out_free, out_load;
    assign s_sat    = (|r_total[33:32]) ? '1 : r_total[31:0];
    assign upd      = !r_run_open || (s_sat < r_best_score);
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign out_load = (r_state == S_FIN) && r_last && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_center <= '0;
            r_ref_picked <= '0;
            r_ref_normal <= '0;
            r_ref_area   <= '0;
            r_diag       <= DIAG_W'(1);
            r_ref_index  <= '0;
            r_state      <= S_IDLE;
            r_acc_en     <= 1'b0;
            r_run_open   <= 1'b0;
            r_best_score <= '1;
            r_best_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_CENTER: r_ref_center <= i_cfg_wdata;
                    REG_PICKED: r_ref_picked <= i_cfg_wdata;
                    REG_NORMAL: r_ref_normal <= i_cfg_wdata[47:0];
                    REG_AREA:   r_ref_area   <= i_cfg_wdata[AREA_W-1:0];
                    REG_DIAG:   r_diag       <= i_cfg_wdata[DIAG_W-1:0];
                    REG_INDEX:  r_ref_index  <= i_cfg_wdata[IDX_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // Products leave the multiplier in the cycle after their operands.
            if (r_acc_en) begin
                case (r_acc_grp)
                    GRP_DC:   r_dc  <= r_dc + r_prod[DIST_W-1:0];
                    GRP_DP:   r_dp  <= r_dp + r_prod[DIST_W-1:0];
                    GRP_RR:   r_nr  <= r_nr + r_prod[31:0];
                    GRP_NN:   r_nc  <= r_nc + r_prod[31:0];
                    GRP_RN:   r_dot <= r_dot + r_prod[32:0];
                    GRP_NRNC: r_nn  <= r_prod[63:0];
                    default: ;
                endcase
            end
            r_acc_en <= (r_state == S_MUL) && (r_grp != GRP_END);

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_cc[0] <= i_s_axis_tdata[20:0];
                        r_cc[1] <= i_s_axis_tdata[41:21];
                        r_cc[2] <= i_s_axis_tdata[62:42];
                        r_cn[0] <= i_s_axis_tdata[78:63];
                        r_cn[1] <= i_s_axis_tdata[94:79];
                        r_cn[2] <= i_s_axis_tdata[110:95];
                        r_ca    <= i_s_axis_tdata[142:111];
                        r_cidx  <= i_s_axis_tdata[174:143];
                        r_last  <= i_s_axis_tlast;
                        r_geom  <= has_geom;
                        r_dc    <= '0;
                        r_dp    <= '0;
                        r_nr    <= '0;
                        r_nc    <= '0;
                        r_dot   <= '0;
                        r_total <= '0;
                        r_grp   <= GRP_DC;
                        r_lane  <= '0;
                        r_state <= has_geom ? S_MUL : S_FIN;
                    end
                end
                S_MUL: begin
                    r_acc_grp <= r_grp;
                    if (r_grp == GRP_END) begin
                        r_state <= S_PREP_D;
                    end else if (r_grp == GRP_NRNC) begin
                        r_grp <= GRP_END;
                    end else if (r_lane == LANE_LAST) begin
                        r_lane <= '0;
                        r_grp  <= 3'(r_grp + 3'd1);
                    end else begin
                        r_lane <= 2'(r_lane + 2'd1);
                    end
                end
                S_PREP_D: begin
                    r_term <= TERM_DIST;
                    if (!(have_c || have_p)) begin
                        r_state <= S_PREP_N;
                    end else if (d_ovf) begin
                        r_total <= r_total + 34'({SCORE_W{1'b1}});
                        r_state <= S_PREP_N;
                    end else begin
                        r_drem  <= DIAG_W'(num_d[NW-1:32]);
                        r_dq    <= num_d[31:0];
                        r_dden  <= dg_eff;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_PREP_N: begin
                    r_term <= TERM_NORM;
                    if ((r_nr != '0) && (r_nc != '0)) begin
                        r_sval  <= r_nn;
                        r_srem  <= '0;
                        r_sroot <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_state <= S_PREP_A;
                    end
                end
                S_SQRT: begin
                    r_srem  <= sq_ge ? sq_t - sq_trial : sq_t;
                    r_sroot <= {r_sroot[30:0], sq_ge};
                    r_sval  <= {r_sval[61:0], 2'b00};
                    r_cnt   <= CNT_W'(r_cnt + 1'b1);
                    if (r_cnt == CNT_W'(STEPS - 1)) begin
                        r_state <= S_PREP_ND;
                    end
                end
                S_PREP_ND: begin
                    r_drem  <= DIAG_W'(num_n[NW-1:32]);
                    r_dq    <= num_n[31:0];
                    r_dden  <= {12'b0, r_sroot};
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_PREP_A: begin
                    r_term <= TERM_AREA;
                    if ((r_ref_area != '0) && (r_ca != '0)) begin
                        r_drem  <= DIAG_W'(num_a[NW-1:32]);
                        r_dq    <= num_a[31:0];
                        r_dden  <= {12'b0, a_max};
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    r_drem <= div_ge ? DIAG_W'(div_t - {1'b0, r_dden}) : div_t[DIAG_W-1:0];
                    r_dq   <= {r_dq[30:0], div_ge};
                    r_cnt  <= CNT_W'(r_cnt + 1'b1);
                    if (r_cnt == CNT_W'(STEPS - 1)) begin
                        r_state <= S_DEND;
                    end
                end
                S_DEND: begin
                    if (r_term == TERM_DIST) begin
                        r_total <= r_total + {2'b00, r_dq};
                        r_state <= S_PREP_N;
                    end else begin
                        r_state <= S_WMUL;
                    end
                end
                S_WMUL: begin
                    r_state <= S_WACC;
                end
                S_WACC: begin
                    r_total <= r_total + {2'b00, r_prod[S +: 32]};
                    r_state <= (r_term == TERM_NORM) ? S_PREP_A : S_FIN;
                end
                S_FIN: begin
                    if (!r_last || out_free) begin
                        r_state <= S_IDLE;
                        if (r_last) begin
                            r_out_geom   <= r_geom;
                            if (r_geom) begin
                                r_out_idx   <= upd ? r_cidx : r_best_idx;
                                r_out_score <= upd ? s_sat : r_best_score;
                            end else begin
                                r_out_idx   <= r_ref_index;
                                r_out_score <= '1;
                            end
                            r_run_open   <= 1'b0;
                            r_best_score <= '1;
                            r_best_idx   <= r_ref_index;
                        end else if (r_geom) begin
                            r_run_open <= 1'b1;
                            if (upd) begin
                                r_best_score <= s_sat;
                                r_best_idx   <= r_cidx;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_score, r_out_idx};
    assign o_m_axis_tuser  = r_out_geom;

    `FRBM_ASSERT(a_busy_after_accept, (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready, "accepted a beat while busy")
    `FRBM_ASSERT(a_result_from_fin, $rose(o_m_axis_tvalid) |-> $past(r_state == S_FIN), "result raised outside the final step")
    `FRBM_ASSERT(a_no_geom_score, (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata[63:32] == 32'hFFFF_FFFF), "unscored result must carry a saturated score")
    `FRBM_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_axis_tvalid, "output not empty after reset")

endmodule

[bench/face_reference_best_match_core_test.sv]
// ---------------------------------------------------------------------------
// Face reference best match core testbench
// Streams candidate faces under several reference settings, predicts each
// run's best index and score and compares every result beat field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module face_reference_best_match_core_test;
    import frbm_pkg::*;

    localparam int SF        = 24;
    localparam int WDOG_MAX  = 4000;
    localparam int SETTLE    = 200;
    localparam longint unsigned ONE_Q = 64'd1 << SF;
    localparam longint unsigned W20   = (ONE_Q + 2) / 5;
    localparam longint unsigned W05   = (ONE_Q + 10) / 20;

    typedef struct {
        logic signed [COORD_W-1:0] ctr [3];
        logic signed [NORM_W-1:0]  nrm [3];
        logic [AREA_W-1:0]         area;
        logic [IDX_W-1:0]          index;
        logic                      last;
    } cand_t;

    typedef struct {
        logic [IDX_W-1:0]   index;
        logic [SCORE_W-1:0] score;
        logic               geo;
    } match_t;

    class face_match_board;
        logic [62:0] center_reg, picked_reg;
        logic [47:0] normal_reg;
        logic [31:0] area_reg, index_reg;
        logic [43:0] diag_reg;
        logic [31:0] best_score, best_index;
        bit          run_open;
        match_t      pending [$];
        int          errors, result_count, geo_matches, no_geo_matches;

        function new();
            center_reg = '0; picked_reg = '0; normal_reg = '0; area_reg = '0;
            diag_reg = 44'd1; index_reg = '0;
            close_run();
        endfunction

        function void close_run();
            best_score = '1;
            best_index = index_reg;
            run_open   = 0;
        endfunction

        function void write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] val);
            case (addr)
                REG_CENTER: center_reg = val;
                REG_PICKED: picked_reg = val;
                REG_NORMAL: normal_reg = val[47:0];
                REG_AREA:   area_reg   = val[31:0];
                REG_DIAG:   diag_reg   = val[43:0];
                REG_INDEX:  index_reg  = val[31:0];
                default: ;
            endcase
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint unsigned dist_to(logic [62:0] pt, cand_t c);
            longint signed d;
            longint unsigned s;
            s = 0;
            for (int k = 0; k < 3; k++) begin
                d = longint'($signed(pt[k*21 +: 21])) - longint'(c.ctr[k]);
                if (d < 0) d = -d;
                s += longint'(d) * longint'(d);
            end
            return s;
        endfunction

        // Truncated Q8.24 quotient by long division, all ones when it overflows.
        function longint unsigned ratio_q(longint unsigned num, longint unsigned den);
            longint unsigned q, r, f;
            q = num / den;
            r = num % den;
            f = 0;
            if (q >= 256) return 64'hFFFF_FFFF;
            for (int i = 0; i < SF; i++) begin
                r = r << 1;
                f = f << 1;
                if (r >= den) begin
                    r -= den;
                    f |= 1;
                end
            end
            return (q << SF) | f;
        endfunction

        function logic [31:0] score_of(cand_t c);
            longint unsigned total, d, d2, nr, nc, cq, mx, df, ca, dg;
            longint signed dot, rn, cn;
            bit have;
            total = 0;
            have  = 0;
            d     = 0;
            if (center_reg != 0) begin
                d    = dist_to(center_reg, c);
                have = 1;
            end
            if (picked_reg != 0) begin
                d2 = dist_to(picked_reg, c);
                if (!have || d2 < d) d = d2;
                have = 1;
            end
            if (have) begin
                dg = (diag_reg != 0) ? 64'(diag_reg) : 64'd1;
                total += ratio_q(d, dg);
            end
            nr = 0; nc = 0; dot = 0;
            for (int k = 0; k < 3; k++) begin
                rn = longint'($signed(normal_reg[k*16 +: 16]));
                cn = longint'(c.nrm[k]);
                nr += rn * rn;
                nc += cn * cn;
                dot += rn * cn;
            end
            if (nr != 0 && nc != 0) begin
                if (dot < 0) dot = -dot;
                cq = (longint'(dot) << SF) / isqrt(nr * nc);
                if (cq > ONE_Q) cq = ONE_Q;
                total += ((ONE_Q - cq) * W20) >> SF;
            end
            ca = 64'(c.area);
            if (area_reg != 0 && ca != 0) begin
                mx = (area_reg > ca) ? area_reg : ca;
                df = (area_reg > ca) ? area_reg - ca : ca - area_reg;
                total += ((((df << SF) / mx)) * W05) >> SF;
            end
            return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        endfunction

        function void note_candidate(cand_t c);
            logic [31:0] s;
            match_t m;
            if (center_reg != 0 || picked_reg != 0 || normal_reg != 0 || area_reg != 0) begin
                s = score_of(c);
                if (!run_open || s < best_score) begin
                    best_score = s;
                    best_index = c.index;
                end
                run_open = 1;
                if (!c.last) return;
                m = '{best_index, best_score, 1'b1};
            end else begin
                if (!c.last) return;
                m = '{index_reg, 32'hFFFF_FFFF, 1'b0};
            end
            pending = {pending, m};
            close_run();
        endfunction

        function void check_match(logic [31:0] index, logic [31:0] score, logic geo);
            match_t m;
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: index %0h score %0h", index, score);
                errors++;
                return;
            end
            m = pending.pop_front();
            result_count++;
            if (m.geo) geo_matches++; else no_geo_matches++;
            if (index !== m.index) begin
                $error("best_face_index: expected %0h, actual %0h", m.index, index);
                errors++;
            end
            if (score !== m.score) begin
                $error("best_score: expected %0h, actual %0h", m.score, score);
                errors++;
            end
            if (geo !== m.geo) begin
                $error("used_geometry: expected %0b, actual %0b", m.geo, geo);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_we = 0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_wdata = '0;
    logic              i_s_axis_tvalid = 0;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata = '0;
    logic              i_s_axis_tlast = 0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 0;
    logic [OUT_W-1:0]  o_m_axis_tdata;
    logic              o_m_axis_tuser;

    face_reference_best_match_core u_top (.*);

    face_match_board board = new();
    bit  steady;       // no idling on either side while set
    int  sent_count;
    int  config_count;
    int  quiet_cycles;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_MAX) begin
            $display("timeout: no beat for %0d cycles", WDOG_MAX);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stalls before each beat, unless steady is set.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                i_m_axis_tready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            board.check_match(o_m_axis_tdata[31:0], o_m_axis_tdata[63:32], o_m_axis_tuser);
        end
    end

    // One register write, with the write enable dropped again before the task returns.
    task automatic write_cfg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] val);
        i_cfg_we    <= 1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        board.write_reg(addr, val);
        config_count++;
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [62:0] ctr, logic [62:0] pick, logic [47:0] nrm,
                             logic [31:0] area, logic [43:0] diag, logic [31:0] index);
        write_cfg(REG_CENTER, ctr);
        write_cfg(REG_PICKED, pick);
        write_cfg(REG_NORMAL, nrm);
        write_cfg(REG_AREA, area);
        write_cfg(REG_DIAG, diag);
        write_cfg(REG_INDEX, index);
    endtask

    task automatic send_cand(cand_t c);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata  <= {1'b0, c.index, c.area, c.nrm[2], c.nrm[1], c.nrm[0],
                            c.ctr[2], c.ctr[1], c.ctr[0]};
        i_s_axis_tlast  <= c.last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_candidate(c);
        sent_count++;
    endtask

    // Drains every pending result and lets any candidate still in flight finish.
    task automatic settle();
        i_s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic cand_t make_cand(int x, int y, int z, int nx, int ny, int nz,
                                        logic [31:0] area, logic [31:0] index, bit last);
        cand_t c;
        c.ctr[0] = 21'(x); c.ctr[1] = 21'(y); c.ctr[2] = 21'(z);
        c.nrm[0] = 16'(nx); c.nrm[1] = 16'(ny); c.nrm[2] = 16'(nz);
        c.area = area; c.index = index; c.last = last;
        return c;
    endfunction

    function automatic logic [62:0] pack_pt(int x, int y, int z);
        logic [20:0] a, b, d;
        a = 21'(x); b = 21'(y); d = 21'(z);
        return {d, b, a};
    endfunction

    function automatic logic [20:0] near_coord(logic [20:0] base);
        int spread;
        spread = 1 << $urandom_range(0, 20);
        return base + 21'($urandom_range(0, 2 * spread)) - 21'(spread);
    endfunction

    function automatic cand_t random_cand(bit last);
        cand_t c;
        logic [62:0] anchor;
        anchor = $urandom_range(0, 1) ? board.center_reg : board.picked_reg;
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 9) < 7) c.ctr[k] = near_coord(anchor[k*21 +: 21]);
            else c.ctr[k] = 21'($urandom());
        end
        case ($urandom_range(0, 9))
            0: for (int k = 0; k < 3; k++) c.nrm[k] = '0;
            1, 2, 3: for (int k = 0; k < 3; k++) c.nrm[k] = 16'($urandom());
            default: for (int k = 0; k < 3; k++)
                c.nrm[k] = board.normal_reg[k*16 +: 16] + 16'($urandom_range(0, 512)) - 16'd256;
        endcase
        case ($urandom_range(0, 9))
            0: c.area = '0;
            1, 2, 3: c.area = $urandom();
            default: c.area = board.area_reg + 32'($urandom_range(0, 65535)) - 32'd32768;
        endcase
        c.index = $urandom();
        c.last  = last;
        return c;
    endfunction

    task automatic random_config();
        logic [62:0] ctr, pick;
        logic [47:0] nrm;
        logic [31:0] area;
        logic [43:0] diag;
        ctr  = $urandom_range(0, 3) == 0 ? '0 : 63'({$urandom(), $urandom()});
        pick = $urandom_range(0, 3) == 0 ? '0 : 63'({$urandom(), $urandom()});
        nrm  = $urandom_range(0, 4) == 0 ? '0 : 48'({$urandom(), $urandom()});
        area = $urandom_range(0, 4) == 0 ? '0 : $urandom();
        case ($urandom_range(0, 5))
            0: diag = '0;
            1: diag = '1;
            2: diag = 44'($urandom_range(1, 1000));
            default: diag = 44'({$urandom(), $urandom()} >> $urandom_range(0, 40));
        endcase
        // Now and then a reference with no geometry at all.
        if ($urandom_range(0, 7) == 0) begin
            ctr = '0; pick = '0; nrm = '0; area = '0;
        end
        write_all(ctr, pick, nrm, area, diag, $urandom());
    endtask

    initial begin
        int remaining, run_len;
        steady = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Reference with center, normal and area but no picked point, and a zero diagonal.
        write_all(pack_pt(1000, -2000, 3000), '0, {16'd0, 16'd0, 16'd16384}, 32'h0001_0000,
                  '0, 32'hFFFF_FFFF);
        send_cand(make_cand(1000, -2000, 3000, 16384, 0, 0, 32'h0001_0000, 32'd7, 0));
        // Equal score must keep the earlier index.
        send_cand(make_cand(1000, -2000, 3000, 16384, 0, 0, 32'h0001_0000, 32'd8, 0));
        send_cand(make_cand(-1048576, 1048575, -1048576, 0, 0, 0, 0, 32'h8000_0000, 0));
        send_cand(make_cand(1048575, -1048576, 1048575, -32768, -32768, -32768,
                            32'hFFFF_FFFF, 32'h7FFF_FFFF, 1));
        // Saturated first candidate is still taken.
        send_cand(make_cand(-1048576, -1048576, -1048576, 0, 16384, 0, 32'd1, 32'd3, 1));
        settle();

        // No geometry: results carry the reference index.
        write_all('0, '0, '0, '0, 44'd1, 32'h7FFF_FFFF);
        write_cfg(3'd7, '1);
        send_cand(make_cand(5, 5, 5, 1, 1, 1, 32'd9, 32'd1, 0));
        send_cand(make_cand(-5, 5, -5, 0, 0, 0, 32'd0, 32'd2, 1));
        send_cand(make_cand(0, 0, 0, 0, 0, 0, 32'd0, 32'd0, 1));
        settle();

        // Area only, largest diagonal.
        write_all('0, '0, '0, 32'hFFFF_FFFF, '1, 32'h8000_0000);
        send_cand(make_cand(0, 0, 0, 0, 0, 0, 32'd1, 32'd10, 0));
        send_cand(make_cand(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'd11, 0));
        send_cand(make_cand(0, 0, 0, 0, 0, 0, 32'h8000_0000, 32'd12, 1));
        settle();

        // Picked point and center both set, extreme normals that clamp the cosine.
        write_all(pack_pt(-1048576, -1048576, -1048576), pack_pt(1048575, 1048575, 1048575),
                  {16'h8000, 16'h8000, 16'h8000}, '0, 44'd4096, 32'd0);
        send_cand(make_cand(1048575, 1048575, 1048570, -32768, -32768, -32768, 32'd5, 32'd20, 0));
        send_cand(make_cand(-1048570, -1048576, -1048576, 32767, 32767, 32767, 32'd5, 32'd21, 0));
        send_cand(make_cand(0, 0, 0, 32767, -32768, 0, 32'd5, 32'd22, 0));
        send_cand(make_cand(1048575, 1048575, 1048575, 0, 0, 1, 32'd5, 32'd23, 1));
        settle();

        for (int phase = 0; phase < 10; phase++) begin
            random_config();
            steady = (phase % 4 == 3);
            remaining = 155;
            while (remaining > 0) begin
                run_len = $urandom_range(1, 8);
                if (run_len > remaining) run_len = remaining;
                for (int i = 0; i < run_len; i++) begin
                    send_cand(random_cand(i == run_len - 1));
                end
                remaining -= run_len;
            end
            settle();
        end
        steady = 0;

        $display("Sent %0d candidates over %0d register writes.", sent_count, config_count);
        $display("Checked %0d results: %0d scored, %0d without reference geometry.",
                 board.result_count, board.geo_matches, board.no_geo_matches);
        if (board.pending.size() != 0) begin
            $error("%0d expected results never arrived", board.pending.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
